### rtl/dcp_pkg.sv
package dcp_pkg;

  // result status codes
  localparam logic [2:0] STATUS_OK          = 3'd0;
  localparam logic [2:0] STATUS_WRONG_CMD   = 3'd1;
  localparam logic [2:0] STATUS_NO_LEFT     = 3'd2;
  localparam logic [2:0] STATUS_INCOMPLETE  = 3'd3;
  localparam logic [2:0] STATUS_SYNTAX      = 3'd4;

  // characters the parser looks for
  localparam logic [7:0] CH_NEWLINE = 8'h0a;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_EQUAL   = 8'h3d;
  localparam logic [7:0] CH_MINUS   = 8'h2d;
  localparam logic [7:0] CH_COMMA   = 8'h2c;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UP_L    = 8'h4c;
  localparam logic [7:0] CH_UP_R    = 8'h52;
  localparam logic [7:0] CH_LOW_R   = 8'h72;
  localparam logic [7:0] CH_LOW_V   = 8'h76;

  localparam logic [9:0] MAX_MAG = 10'd100;

  // 255 * ceil(2^22 / 100): duty = (mag * DUTY_RECIP) >> 22, exact for mag <= 100
  localparam logic [23:0] DUTY_RECIP = 24'd10695720;
  localparam int          DUTY_SHIFT = 22;

  typedef enum logic [4:0] {
    ST_CMD   = 5'b00001,
    ST_V     = 5'b00010,
    ST_R     = 5'b00100,
    ST_VALUE = 5'b01000,
    ST_ERR   = 5'b10000
  } parse_state_t;

  typedef struct packed {
    logic [2:0] status;
    logic       drive_valid;
    logic       left_reverse;
    logic       right_reverse;
    logic [7:0] left_pwm;
    logic [7:0] right_pwm;
  } dcp_result_t;

  function automatic logic [7:0] duty_of(input logic [6:0] mag);
    logic [30:0] prod;
    prod = 31'(mag) * 31'(DUTY_RECIP);
    return prod[DUTY_SHIFT+7:DUTY_SHIFT];
  endfunction

endpackage

### rtl/dcp_in_if.sv
interface dcp_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] char_in;

  modport source (output valid, output mode, output char_in, input ready);
  modport sink (input valid, input mode, input char_in, output ready);
endinterface

### rtl/dcp_out_if.sv
interface dcp_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic       drive_valid;
  logic       left_reverse;
  logic       right_reverse;
  logic [7:0] left_pwm;
  logic [7:0] right_pwm;

  modport source (output valid, output status, output drive_valid, output left_reverse,
                  output right_reverse, output left_pwm, output right_pwm, input ready);
  modport sink (input valid, input status, input drive_valid, input left_reverse,
                input right_reverse, input left_pwm, input right_pwm, output ready);
endinterface

### rtl/drive_command_parser.sv
// drive command parser: takes one request per character on in_chan, where
// mode 1 restarts the parser for a new command and mode 0 carries a byte in
// char_in. the accepted grammar is any number of "rv" pairs, then "LR", then
// two signed decimal values split by a comma, spaces and '=' skipped.
// every newline yields one status request on out_chan; a good line with both
// values also carries per-wheel reverse bits and pwm duty |v|*255/100.
// the result of a newline is presented on out_chan in the cycle after the
// newline is accepted. throughput: one character per cycle while
// in_chan.ready is high, set by the single parser state update and the duty
// multiply ahead of the result register. in_chan.ready is high whenever the
// result register is empty or is being emptied in the same cycle, so a
// stalled receiver holds the pending result and stops input only while that result waits.
// reset (rst_n low, synchronous) puts the parser in the command state with
// cleared values and empties the result register.
module drive_command_parser (
  input  logic          clk,
  input  logic          rst_n,
  dcp_in_if.sink        in_chan,
  dcp_out_if.source     out_chan
);

  logic                 in_fire;
  logic                 res_valid;
  dcp_pkg::dcp_result_t res;
  dcp_pkg::dcp_result_t out_r;
  logic                 out_valid_r;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_fire       = in_chan.valid && in_chan.ready;

  dcp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .mode      (in_chan.mode),
    .char_in   (in_chan.char_in),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= res_valid;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res_valid) begin
      out_r <= res;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.status        = out_r.status;
  assign out_chan.drive_valid   = out_r.drive_valid;
  assign out_chan.left_reverse  = out_r.left_reverse;
  assign out_chan.right_reverse = out_r.right_reverse;
  assign out_chan.left_pwm      = out_r.left_pwm;
  assign out_chan.right_pwm     = out_r.right_pwm;

  // drive fields only travel with an ok status, and are zero otherwise
  a_drive_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.drive_valid |-> out_r.status == dcp_pkg::STATUS_OK)
    else $error("drive fields with non-ok status");

  a_no_drive_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.drive_valid |->
      !out_r.left_reverse && !out_r.right_reverse &&
      out_r.left_pwm == 8'd0 && out_r.right_pwm == 8'd0)
    else $error("drive fields set without drive_valid");

  // a restart never produces a result
  a_restart_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_chan.mode && out_chan.ready |=> !out_valid_r)
    else $error("result after restart request");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_r.status <= dcp_pkg::STATUS_SYNTAX)
    else $error("status code out of range");

endmodule

### rtl/dcp_parser.sv
module dcp_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  logic                mode,
  input  logic [7:0]          char_in,
  output logic                res_valid,
  output dcp_pkg::dcp_result_t res
);

  dcp_pkg::parse_state_t st_r, st_nxt;
  logic [9:0] acc_r, acc_nxt;
  logic       neg_r, neg_nxt;
  logic [6:0] left_mag_r, left_mag_nxt;
  logic       left_rev_r, left_rev_nxt;
  logic       left_present_r, left_present_nxt;

  logic       is_nl;
  logic       is_digit;
  logic [3:0] digit;
  logic [9:0] acc_digit;
  logic       cur_rev;

  assign is_nl     = (char_in == dcp_pkg::CH_NEWLINE);
  assign is_digit  = (char_in >= dcp_pkg::CH_ZERO) && (char_in <= dcp_pkg::CH_NINE);
  assign digit     = 4'(char_in - dcp_pkg::CH_ZERO);
  assign acc_digit = 10'(acc_r * 10'd10 + 10'(digit));
  // accumulator stays at or below 100 while a value is read, so 7 bits carry it
  assign cur_rev   = neg_r && (acc_r[6:0] != 7'd0);

  always_comb begin
    st_nxt           = st_r;
    acc_nxt          = acc_r;
    neg_nxt          = neg_r;
    left_mag_nxt     = left_mag_r;
    left_rev_nxt     = left_rev_r;
    left_present_nxt = left_present_r;
    res_valid        = 1'b0;
    res              = '0;

    if (mode) begin
      st_nxt           = dcp_pkg::ST_CMD;
      acc_nxt          = '0;
      neg_nxt          = 1'b0;
      left_mag_nxt     = '0;
      left_rev_nxt     = 1'b0;
      left_present_nxt = 1'b0;
    end else begin
      unique case (st_r)
        dcp_pkg::ST_CMD: begin
          priority if (char_in == dcp_pkg::CH_UP_L) begin
            st_nxt = dcp_pkg::ST_R;
          end else if (char_in == dcp_pkg::CH_LOW_R) begin
            st_nxt = dcp_pkg::ST_V;
          end else if (is_nl) begin
            res_valid  = 1'b1;
            res.status = dcp_pkg::STATUS_WRONG_CMD;
          end else begin
            st_nxt = dcp_pkg::ST_ERR;
          end
        end
        dcp_pkg::ST_V: begin
          priority if (char_in == dcp_pkg::CH_LOW_V) begin
            st_nxt = dcp_pkg::ST_CMD;
          end else if (is_nl) begin
            res_valid  = 1'b1;
            res.status = dcp_pkg::STATUS_INCOMPLETE;
          end else begin
            st_nxt = dcp_pkg::ST_ERR;
          end
        end
        dcp_pkg::ST_R: begin
          priority if (char_in == dcp_pkg::CH_UP_R) begin
            st_nxt = dcp_pkg::ST_VALUE;
          end else if (is_nl) begin
            res_valid  = 1'b1;
            res.status = dcp_pkg::STATUS_INCOMPLETE;
          end else begin
            st_nxt = dcp_pkg::ST_ERR;
          end
        end
        dcp_pkg::ST_VALUE: begin
          priority if (is_digit) begin
            acc_nxt = acc_digit;
            if (acc_digit > dcp_pkg::MAX_MAG) begin
              st_nxt = dcp_pkg::ST_ERR;
            end
          end else if (char_in == dcp_pkg::CH_SPACE || char_in == dcp_pkg::CH_EQUAL) begin
            st_nxt = st_r;
          end else if (char_in == dcp_pkg::CH_MINUS) begin
            neg_nxt = 1'b1;
          end else if (char_in == dcp_pkg::CH_COMMA) begin
            if (left_present_r) begin
              st_nxt = dcp_pkg::ST_ERR;
            end else begin
              left_mag_nxt     = acc_r[6:0];
              left_rev_nxt     = cur_rev;
              left_present_nxt = 1'b1;
              acc_nxt          = '0;
              neg_nxt          = 1'b0;
            end
          end else if (is_nl) begin
            res_valid = 1'b1;
            if (!left_present_r) begin
              res.status = dcp_pkg::STATUS_NO_LEFT;
            end else begin
              res.status        = dcp_pkg::STATUS_OK;
              res.drive_valid   = 1'b1;
              res.left_reverse  = left_rev_r;
              res.right_reverse = cur_rev;
              res.left_pwm      = dcp_pkg::duty_of(left_mag_r);
              res.right_pwm     = dcp_pkg::duty_of(acc_r[6:0]);
            end
          end else begin
            st_nxt = dcp_pkg::ST_ERR;
          end
        end
        default: begin
          // error state and any stray code: drop everything up to newline
          st_nxt = dcp_pkg::ST_ERR;
          if (is_nl) begin
            res_valid  = 1'b1;
            res.status = dcp_pkg::STATUS_SYNTAX;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r           <= dcp_pkg::ST_CMD;
      acc_r          <= '0;
      neg_r          <= 1'b0;
      left_mag_r     <= '0;
      left_rev_r     <= 1'b0;
      left_present_r <= 1'b0;
    end else if (in_fire) begin
      st_r           <= st_nxt;
      acc_r          <= acc_nxt;
      neg_r          <= neg_nxt;
      left_mag_r     <= left_mag_nxt;
      left_rev_r     <= left_rev_nxt;
      left_present_r <= left_present_nxt;
    end
  end

endmodule

### tb/tb_drive_command_parser.sv
module tb_drive_command_parser;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_REQUESTS = 800;
  localparam int HOLD_CYCLES     = 400;
  localparam int CYCLE_LIMIT     = 150000;

  // predicts the status request of each newline and checks what comes out
  class drive_status_board;
    dcp_pkg::parse_state_t phase;
    logic [9:0]            magnitude;
    logic                  minus_seen;
    logic [7:0]            left_word;
    logic                  left_taken;
    dcp_pkg::dcp_result_t  pending[$];
    int                    errors;
    int                    status_count[5];

    function new();
      restart();
    endfunction

    function void restart();
      phase      = dcp_pkg::ST_CMD;
      magnitude  = '0;
      minus_seen = 1'b0;
      left_word  = '0;
      left_taken = 1'b0;
    endfunction

    // a minus on a zero magnitude gives plain zero
    function logic [7:0] signed_value();
      logic [7:0] mag;
      mag = magnitude[7:0];
      if (minus_seen && mag != 8'd0) return -mag;
      return mag;
    endfunction

    function void wheel(input logic [7:0] v, output logic rev, output logic [7:0] pwm);
      logic [7:0] mag;
      rev = v[7];
      mag = v[7] ? -v : v;
      pwm = 8'((int'(mag) * 255) / 100);
    endfunction

    function void push_status(input logic [2:0] st);
      dcp_pkg::dcp_result_t r;
      r = '0;
      r.status = st;
      pending.push_back(r);
    endfunction

    function void note_request(input logic mode, input logic [7:0] ch);
      dcp_pkg::dcp_result_t r;
      logic nl;
      nl = (ch == dcp_pkg::CH_NEWLINE);
      if (mode) begin
        restart();
        return;
      end
      case (phase)
        dcp_pkg::ST_CMD: begin
          if (ch == dcp_pkg::CH_UP_L) phase = dcp_pkg::ST_R;
          else if (ch == dcp_pkg::CH_LOW_R) phase = dcp_pkg::ST_V;
          else if (nl) push_status(dcp_pkg::STATUS_WRONG_CMD);
          else phase = dcp_pkg::ST_ERR;
        end
        dcp_pkg::ST_V: begin
          if (ch == dcp_pkg::CH_LOW_V) phase = dcp_pkg::ST_CMD;
          else if (nl) push_status(dcp_pkg::STATUS_INCOMPLETE);
          else phase = dcp_pkg::ST_ERR;
        end
        dcp_pkg::ST_R: begin
          if (ch == dcp_pkg::CH_UP_R) phase = dcp_pkg::ST_VALUE;
          else if (nl) push_status(dcp_pkg::STATUS_INCOMPLETE);
          else phase = dcp_pkg::ST_ERR;
        end
        dcp_pkg::ST_VALUE: begin
          if (ch >= dcp_pkg::CH_ZERO && ch <= dcp_pkg::CH_NINE) begin
            magnitude = 10'(magnitude * 10 + (ch - dcp_pkg::CH_ZERO));
            if (magnitude > dcp_pkg::MAX_MAG) phase = dcp_pkg::ST_ERR;
          end else if (ch == dcp_pkg::CH_MINUS) begin
            minus_seen = 1'b1;
          end else if (ch == dcp_pkg::CH_COMMA) begin
            if (left_taken) begin
              phase = dcp_pkg::ST_ERR;
            end else begin
              left_word  = signed_value();
              left_taken = 1'b1;
              magnitude  = '0;
              minus_seen = 1'b0;
            end
          end else if (nl) begin
            if (!left_taken) begin
              push_status(dcp_pkg::STATUS_NO_LEFT);
            end else begin
              r = '0;
              r.status      = dcp_pkg::STATUS_OK;
              r.drive_valid = 1'b1;
              wheel(left_word, r.left_reverse, r.left_pwm);
              wheel(signed_value(), r.right_reverse, r.right_pwm);
              pending.push_back(r);
            end
          end else if (ch != dcp_pkg::CH_SPACE && ch != dcp_pkg::CH_EQUAL) begin
            phase = dcp_pkg::ST_ERR;
          end
        end
        default: begin
          phase = dcp_pkg::ST_ERR;
          if (nl) push_status(dcp_pkg::STATUS_SYNTAX);
        end
      endcase
    endfunction

    function void compare_field(input string name, input int exp_v, input int act_v);
      if (exp_v != act_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(input dcp_pkg::dcp_result_t got);
      dcp_pkg::dcp_result_t exp_r;
      if (pending.size() == 0) begin
        $error("status %0d arrived with no newline waiting for it", got.status);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (exp_r.status < 5) status_count[exp_r.status]++;
      compare_field("status", exp_r.status, got.status);
      compare_field("drive_valid", exp_r.drive_valid, got.drive_valid);
      compare_field("left_reverse", exp_r.left_reverse, got.left_reverse);
      compare_field("right_reverse", exp_r.right_reverse, got.right_reverse);
      compare_field("left_pwm", exp_r.left_pwm, got.left_pwm);
      compare_field("right_pwm", exp_r.right_pwm, got.right_pwm);
    endfunction
  endclass

  logic clk;
  logic rst_n;

  dcp_in_if  in_chan ();
  dcp_out_if out_chan ();

  drive_command_parser i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  drive_status_board board = new();

  int send_idle_pct = 25;
  int recv_idle_pct = 25;
  int sent_requests = 0;
  int cycle_count   = 0;
  int hold_left     = 0;
  bit hold_go       = 1'b0;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL drive_command_parser");
      $finish;
    end
  end

  // both monitors see pre-edge values here
  always @(posedge clk) begin : watch
    dcp_pkg::dcp_result_t seen;
    if (rst_n && in_chan.valid && in_chan.ready)
      board.note_request(in_chan.mode, in_chan.char_in);
    if (rst_n && out_chan.valid && out_chan.ready) begin
      seen.status        = out_chan.status;
      seen.drive_valid   = out_chan.drive_valid;
      seen.left_reverse  = out_chan.left_reverse;
      seen.right_reverse = out_chan.right_reverse;
      seen.left_pwm      = out_chan.left_pwm;
      seen.right_pwm     = out_chan.right_pwm;
      board.check_result(seen);
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go) begin
        hold_go   = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_request(input logic m, input logic [7:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid   <= 1'b1;
    in_chan.mode    <= m;
    in_chan.char_in <= c;
    do @(posedge clk); while (!in_chan.ready);
    sent_requests++;
  endtask

  task automatic put_char(input logic [7:0] c);
    send_request(1'b0, c);
  endtask

  task automatic restart_parser();
    send_request(1'b1, 8'($urandom_range(255)));
  endtask

  task automatic put_prefix(input int pairs);
    repeat (pairs) begin
      put_char(dcp_pkg::CH_LOW_R);
      put_char(dcp_pkg::CH_LOW_V);
    end
    put_char(dcp_pkg::CH_UP_L);
    put_char(dcp_pkg::CH_UP_R);
  endtask

  // digits with optional leading zeros, fillers and a minus anywhere
  task automatic put_value(input int mag, input bit neg);
    string digits;
    int minus_at;
    digits = $sformatf("%0d", mag);
    repeat ($urandom_range(2)) digits = {"0", digits};
    minus_at = neg ? $urandom_range(digits.len()) : -1;
    for (int i = 0; i <= digits.len(); i++) begin
      if ($urandom_range(4) == 0)
        put_char($urandom_range(1) ? dcp_pkg::CH_SPACE : dcp_pkg::CH_EQUAL);
      if (i == minus_at) begin
        put_char(dcp_pkg::CH_MINUS);
        if ($urandom_range(5) == 0) put_char(dcp_pkg::CH_MINUS);
      end
      if (i < digits.len()) put_char(digits[i]);
    end
  endtask

  function automatic int pick_magnitude();
    case ($urandom_range(5))
      0: return 0;
      1: return 100;
      default: return $urandom_range(100);
    endcase
  endfunction

  // the edge first, so the newline accepted last is already in the board
  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (board.pending.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  initial begin
    int kind;
    bit hold_done;
    bit drain_done;
    int stop_at;
    hold_done  = 1'b0;
    drain_done = 1'b0;
    rst_n           = 1'b0;
    in_chan.valid   = 1'b0;
    in_chan.mode    = 1'b0;
    in_chan.char_in = 8'h00;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // newline straight after reset: wrong command
    put_char(dcp_pkg::CH_NEWLINE);
    // newline while waiting for 'v', then for 'R'
    send_request(1'b1, 8'hff);
    put_char(dcp_pkg::CH_LOW_R);
    put_char(dcp_pkg::CH_NEWLINE);
    send_request(1'b1, 8'h00);
    put_char(dcp_pkg::CH_UP_L);
    put_char(dcp_pkg::CH_NEWLINE);
    // no left value, then negative zero left and full right, then a second comma
    restart_parser();
    put_prefix(0);
    put_char(dcp_pkg::CH_NEWLINE);
    put_char(dcp_pkg::CH_MINUS);
    put_char(dcp_pkg::CH_COMMA);
    put_char(dcp_pkg::CH_ZERO + 8'd1);
    put_char(dcp_pkg::CH_ZERO);
    put_char(dcp_pkg::CH_ZERO);
    put_char(dcp_pkg::CH_NEWLINE);
    put_char(dcp_pkg::CH_COMMA);
    put_char(dcp_pkg::CH_NEWLINE);
    // magnitude past the limit, then junk in the error state
    restart_parser();
    put_prefix(0);
    put_char(dcp_pkg::CH_NINE);
    put_char(dcp_pkg::CH_NINE);
    put_char(dcp_pkg::CH_NINE);
    put_char(8'h00);
    put_char(dcp_pkg::CH_NEWLINE);

    stop_at = sent_requests + RANDOM_REQUESTS;
    while (sent_requests < stop_at) begin
      if (!hold_done && sent_requests > stop_at - 550) begin
        hold_go   = 1'b1;
        hold_done = 1'b1;
      end
      if (!drain_done && sent_requests > stop_at - 350) begin
        wait_drained();
        drain_done = 1'b1;
      end
      // quiet stretch with no idling on either side
      if (sent_requests > stop_at - 250 && sent_requests < stop_at - 100) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else begin
        send_idle_pct = 25;
        recv_idle_pct = 25;
      end

      kind = $urandom_range(9);
      restart_parser();
      if (kind < 7) begin
        put_prefix($urandom_range(2));
        put_value(pick_magnitude(), $urandom_range(1));
        put_char(dcp_pkg::CH_COMMA);
        put_value(pick_magnitude(), $urandom_range(1));
        put_char(dcp_pkg::CH_NEWLINE);
        if (kind == 6) begin
          case ($urandom_range(2))
            0: put_char(dcp_pkg::CH_NEWLINE);
            1: begin
              put_char(dcp_pkg::CH_COMMA);
              put_char(dcp_pkg::CH_NEWLINE);
            end
            default: begin
              put_value($urandom_range(9), $urandom_range(1));
              put_char(dcp_pkg::CH_NEWLINE);
            end
          endcase
        end
      end else if (kind == 7) begin
        repeat ($urandom_range(1, 5)) put_char(8'($urandom_range(255)));
        put_char(dcp_pkg::CH_NEWLINE);
      end else if (kind == 8) begin
        case ($urandom_range(3))
          0: put_char(dcp_pkg::CH_NEWLINE);
          1: begin
            put_char(dcp_pkg::CH_LOW_R);
            put_char(dcp_pkg::CH_NEWLINE);
          end
          2: begin
            put_char(dcp_pkg::CH_UP_L);
            put_char(dcp_pkg::CH_NEWLINE);
          end
          default: begin
            put_prefix($urandom_range(1));
            put_value(pick_magnitude(), $urandom_range(1));
            put_char(dcp_pkg::CH_NEWLINE);
          end
        endcase
      end else begin
        put_prefix($urandom_range(1));
        if ($urandom_range(1)) put_value($urandom_range(101, 999), $urandom_range(1));
        else put_value(pick_magnitude(), $urandom_range(1));
        put_char(8'($urandom_range(255)));
        put_char(dcp_pkg::CH_COMMA);
        put_value(pick_magnitude(), $urandom_range(1));
        put_char(dcp_pkg::CH_NEWLINE);
      end
    end

    wait_drained();
    repeat (4) @(posedge clk);
    $display("sent %0d requests; drive lines %0d, wrong command %0d, no left value %0d,",
             sent_requests, board.status_count[dcp_pkg::STATUS_OK],
             board.status_count[dcp_pkg::STATUS_WRONG_CMD],
             board.status_count[dcp_pkg::STATUS_NO_LEFT]);
    $display("incomplete keyword %0d, syntax error %0d, mismatches %0d",
             board.status_count[dcp_pkg::STATUS_INCOMPLETE],
             board.status_count[dcp_pkg::STATUS_SYNTAX], board.errors);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("PASS drive_command_parser");
    end else begin
      $display("FAIL drive_command_parser");
    end
    $finish;
  end

endmodule
